/* sv/dac_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dac_pkg
// Shared constants, types and controller states of the denied access counter
// table.
// ----------------------------------------------------------------------------
package dac_pkg;

    localparam int DAC_TABLE_DEPTH  = 32;
    localparam int DAC_RESULT_LIMIT = 32;
    localparam int UID_W            = 31;
    localparam int CNT_W            = 16;
    localparam int ENTRY_W          = UID_W + CNT_W;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    localparam logic KIND_ACCESS = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LK_CHK,
        ST_LK_CMP,
        ST_RP_CHK,
        ST_RP_CMP,
        ST_RP_DONE,
        ST_RP_FINAL
    } t_dac_state;

    // controller to datapath
    typedef struct packed {
        logic lk_start;
        logic rp_start;
        logic pass_start;
        logic rd;
        logic idx_inc;
        logic append;
        logic bump;
        logic cmp;
        logic take;
        logic emit_pend;
        logic emit_last;
        logic emit_none;
    } t_dac_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_end;
        logic match;
        logic found;
        logic pend_valid;
        logic at_limit;
        logic out_free;
    } t_dac_sts;

endpackage

/* sv/denied_access_counter_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// denied_access_counter_table
// Per-user denied access counters with a report in ascending user id order.
// ----------------------------------------------------------------------------
// One item at a time. A denied access record scans the filled entries, one
// entry at a time through the table RAM's registered read port, with a read
// state followed by a compare state; a record that is not denied is taken
// in idle. A report runs one selection pass over the filled entries per
// reported word, plus one closing pass unless the result limit is reached,
// and takes longer while the output is stalled. Results leave through an
// output register, so the last word of a report may wait there while the
// next item is taken. The table is empty after reset with no clearing pass.
// ----------------------------------------------------------------------------
module denied_access_counter_table #(
    parameter int TABLE_DEPTH = dac_pkg::DAC_TABLE_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_kind,
    input  logic [dac_pkg::UID_W-1:0] i_user_id,
    input  logic                      i_denied,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [dac_pkg::CNT_W-1:0] i_cfg_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [dac_pkg::UID_W-1:0] o_user_id_out,
    output logic [dac_pkg::CNT_W-1:0] o_denied_count,
    output logic                      o_none,
    output logic                      o_overflow,
    output logic                      o_last
);

    dac_pkg::t_dac_cmd cmd;
    dac_pkg::t_dac_sts sts;

    dac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_denied   (i_denied),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dac_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_user_id      (i_user_id),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_user_id_out  (o_user_id_out),
        .o_denied_count (o_denied_count),
        .o_none         (o_none),
        .o_overflow     (o_overflow),
        .o_last         (o_last)
    );

endmodule

/* sv/dac_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dac_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/dac_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dac_ctrl
// Controller: sequences table lookups, appends and the sorted report passes.
// ----------------------------------------------------------------------------
module dac_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_kind,
    input  logic                i_denied,
    output logic                o_in_stall,
    input  dac_pkg::t_dac_sts   i_sts,
    output dac_pkg::t_dac_cmd   o_cmd
);

    dac_pkg::t_dac_state r_state;
    dac_pkg::t_dac_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dac_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != dac_pkg::ST_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dac_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_kind == dac_pkg::KIND_REPORT) begin
                        n_state = dac_pkg::ST_RP_CHK;
                    end else if (i_denied) begin
                        n_state = dac_pkg::ST_LK_CHK;
                    end
                end
            end
            dac_pkg::ST_LK_CHK: begin
                n_state = i_sts.scan_end ? dac_pkg::ST_IDLE : dac_pkg::ST_LK_CMP;
            end
            dac_pkg::ST_LK_CMP: begin
                n_state = i_sts.match ? dac_pkg::ST_IDLE : dac_pkg::ST_LK_CHK;
            end
            dac_pkg::ST_RP_CHK: begin
                n_state = i_sts.scan_end ? dac_pkg::ST_RP_DONE : dac_pkg::ST_RP_CMP;
            end
            dac_pkg::ST_RP_CMP: begin
                n_state = dac_pkg::ST_RP_CHK;
            end
            dac_pkg::ST_RP_DONE: begin
                if (i_sts.found) begin
                    if (!i_sts.pend_valid || i_sts.out_free) begin
                        n_state = i_sts.at_limit ? dac_pkg::ST_RP_FINAL
                                                 : dac_pkg::ST_RP_CHK;
                    end
                end else if (i_sts.pend_valid) begin
                    n_state = dac_pkg::ST_RP_FINAL;
                end else if (i_sts.out_free) begin
                    n_state = dac_pkg::ST_IDLE;
                end
            end
            dac_pkg::ST_RP_FINAL: begin
                if (i_sts.out_free) begin
                    n_state = dac_pkg::ST_IDLE;
                end
            end
            default: n_state = dac_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            dac_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_kind == dac_pkg::KIND_REPORT) begin
                        o_cmd.rp_start = 1'b1;
                    end else if (i_denied) begin
                        o_cmd.lk_start = 1'b1;
                    end
                end
            end
            dac_pkg::ST_LK_CHK: begin
                if (i_sts.scan_end) begin
                    o_cmd.append = 1'b1;
                end else begin
                    o_cmd.rd = 1'b1;
                end
            end
            dac_pkg::ST_LK_CMP: begin
                if (i_sts.match) begin
                    o_cmd.bump = 1'b1;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            dac_pkg::ST_RP_CHK: begin
                o_cmd.rd = !i_sts.scan_end;
            end
            dac_pkg::ST_RP_CMP: begin
                o_cmd.cmp     = 1'b1;
                o_cmd.idx_inc = 1'b1;
            end
            dac_pkg::ST_RP_DONE: begin
                if (i_sts.found) begin
                    // the pending word is not the last one: a larger key exists
                    if (!i_sts.pend_valid || i_sts.out_free) begin
                        o_cmd.emit_pend  = i_sts.pend_valid;
                        o_cmd.take       = 1'b1;
                        o_cmd.pass_start = !i_sts.at_limit;
                    end
                end else if (!i_sts.pend_valid && i_sts.out_free) begin
                    o_cmd.emit_none = 1'b1;
                end
            end
            dac_pkg::ST_RP_FINAL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_pend = 1'b1;
                    o_cmd.emit_last = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

/* sv/dac_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dac_dp
// Datapath: entry table, scan index, candidate selection and output register.
// ----------------------------------------------------------------------------
module dac_dp #(
    parameter int TABLE_DEPTH = dac_pkg::DAC_TABLE_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dac_pkg::t_dac_cmd         i_cmd,
    output dac_pkg::t_dac_sts         o_sts,
    input  logic [dac_pkg::UID_W-1:0] i_user_id,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [dac_pkg::CNT_W-1:0] i_cfg_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [dac_pkg::UID_W-1:0] o_user_id_out,
    output logic [dac_pkg::CNT_W-1:0] o_denied_count,
    output logic                      o_none,
    output logic                      o_overflow,
    output logic                      o_last
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int FW = $clog2(dac_pkg::DAC_RESULT_LIMIT + 1);

    localparam logic [CW-1:0] DEPTH_C     = CW'(TABLE_DEPTH);
    localparam logic [FW-1:0] LIMIT_LAST  = FW'(dac_pkg::DAC_RESULT_LIMIT - 1);

    logic [CW-1:0]                 r_used;
    logic [CW-1:0]                 r_idx;
    logic                          r_overflow;
    logic [dac_pkg::CNT_W-1:0]     r_min_count;
    logic [dac_pkg::UID_W-1:0]     r_uid;
    logic                          r_found;
    logic [dac_pkg::UID_W-1:0]     r_best_key;
    logic [dac_pkg::CNT_W-1:0]     r_best_cnt;
    logic                          r_pend_valid;
    logic [dac_pkg::UID_W-1:0]     r_pend_key;
    logic [dac_pkg::CNT_W-1:0]     r_pend_cnt;
    logic [FW-1:0]                 r_found_cnt;
    logic                          r_out_valid;
    logic [dac_pkg::UID_W-1:0]     r_out_uid;
    logic [dac_pkg::CNT_W-1:0]     r_out_cnt;
    logic                          r_out_none;
    logic                          r_out_last;
    logic                          r_out_ovf;

    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [dac_pkg::ENTRY_W-1:0]   wr_data;
    logic [dac_pkg::ENTRY_W-1:0]   rd_data;
    logic [dac_pkg::UID_W-1:0]     rd_key;
    logic [dac_pkg::CNT_W-1:0]     rd_cnt;
    logic [dac_pkg::CNT_W-1:0]     cnt_inc;
    logic                          is_cand;
    logic                          has_room;
    logic                          out_free;

    assign rd_key   = rd_data[dac_pkg::ENTRY_W-1 -: dac_pkg::UID_W];
    assign rd_cnt   = rd_data[dac_pkg::CNT_W-1:0];
    assign cnt_inc  = (rd_cnt == dac_pkg::COUNT_MAX) ? rd_cnt : rd_cnt + 1'b1;
    assign has_room = (r_used < DEPTH_C);
    assign out_free = !r_out_valid || !i_out_stall;

    // next report word: qualifies, above the pending key, below the best so far
    assign is_cand = (rd_cnt >= r_min_count)
                   && (!r_pend_valid || (rd_key > r_pend_key))
                   && (!r_found || (rd_key < r_best_key));

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx[AW-1:0];
        wr_data = {rd_key, cnt_inc};
        if (i_cmd.append && has_room) begin
            wr_en   = 1'b1;
            wr_addr = r_used[AW-1:0];
            wr_data = {r_uid, dac_pkg::CNT_W'(1)};
        end else if (i_cmd.bump) begin
            wr_en = 1'b1;
        end
    end

    dac_ram #(
        .WIDTH (dac_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= '0;
            r_overflow   <= 1'b0;
            r_min_count  <= '0;
            r_found      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_found_cnt  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_min_count <= i_cfg_data;
            end
            if (i_cmd.append) begin
                if (has_room) begin
                    r_used <= r_used + 1'b1;
                end else begin
                    r_overflow <= 1'b1;
                end
            end
            if (i_cmd.rp_start || i_cmd.pass_start) begin
                r_found <= 1'b0;
            end else if (i_cmd.cmp && is_cand) begin
                r_found <= 1'b1;
            end
            if (i_cmd.rp_start) begin
                r_pend_valid <= 1'b0;
                r_found_cnt  <= '0;
            end else if (i_cmd.take) begin
                r_pend_valid <= 1'b1;
                r_found_cnt  <= r_found_cnt + 1'b1;
            end
            if (i_cmd.emit_pend || i_cmd.emit_none) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.lk_start) begin
            r_uid <= i_user_id;
        end
        if (i_cmd.lk_start || i_cmd.rp_start || i_cmd.pass_start) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.cmp && is_cand) begin
            r_best_key <= rd_key;
            r_best_cnt <= rd_cnt;
        end
        if (i_cmd.take) begin
            r_pend_key <= r_best_key;
            r_pend_cnt <= r_best_cnt;
        end
        if (i_cmd.emit_pend) begin
            r_out_uid  <= r_pend_key;
            r_out_cnt  <= r_pend_cnt;
            r_out_none <= 1'b0;
            r_out_last <= i_cmd.emit_last;
            r_out_ovf  <= r_overflow;
        end else if (i_cmd.emit_none) begin
            r_out_uid  <= '0;
            r_out_cnt  <= '0;
            r_out_none <= 1'b1;
            r_out_last <= 1'b1;
            r_out_ovf  <= r_overflow;
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_user_id_out  = r_out_uid;
    assign o_denied_count = r_out_cnt;
    assign o_none         = r_out_none;
    assign o_overflow     = r_out_ovf;
    assign o_last         = r_out_last;

    assign o_sts.scan_end   = (r_idx == r_used);
    assign o_sts.match      = (rd_key == r_uid);
    assign o_sts.found      = r_found;
    assign o_sts.pend_valid = r_pend_valid;
    assign o_sts.at_limit   = (r_found_cnt == LIMIT_LAST);
    assign o_sts.out_free   = out_free;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= DEPTH_C)
        else $error("entry count beyond table depth");

    a_ovf_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_overflow) |-> (r_used == DEPTH_C))
        else $error("overflow marked with room left in the table");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_pend || i_cmd.emit_none) |-> out_free)
        else $error("output word loaded over an untaken word");

    a_emit_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_pend |-> r_pend_valid)
        else $error("report word emitted with nothing pending");

    a_found_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found_cnt <= FW'(dac_pkg::DAC_RESULT_LIMIT))
        else $error("report word count beyond result limit");

endmodule
